[rtl/agr_pkg.sv]
package agr_pkg;

  // Width of the gravity filter coefficient (Q0.16).
  localparam int ALPHA_W = 16;

  // Coefficient after reset: 0.95 in Q0.16.
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd62259;

  // One in Q1.16. The sample weight is BETA_ONE minus alpha.
  localparam int BETA_W = ALPHA_W + 1;
  localparam logic [BETA_W-1:0] BETA_ONE = 17'h10000;

  // Narrowest left multiplier operand: beta as a signed value.
  localparam int MUL_A_MIN_W = BETA_W + 1;

  // Width of the result field.
  localparam int JM_W = 18;

endpackage

[rtl/agr_in_if.sv]
interface agr_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] accel_x;
  logic signed [SAMPLE_WIDTH-1:0] accel_y;
  logic signed [SAMPLE_WIDTH-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

[rtl/agr_out_if.sv]
interface agr_out_if;
  logic                        valid;
  logic                        ready;
  logic [agr_pkg::JM_W-1:0]    jerk_magnitude;

  modport source (output valid, output jerk_magnitude, input ready);
  modport sink (input valid, input jerk_magnitude, output ready);
endinterface

[rtl/accel_gravity_removal_jerk_magnitude_unit.sv]
// Gravity removal and jerk magnitude for a three-axis accelerometer. Each
// input transfer carries one signed sample per axis. The first sample after
// reset only loads the gravity estimates and gives no result; every later
// sample updates the per-axis gravity low-pass (alpha from cfg_wdata, Q0.16),
// removes it, and returns floor(sqrt(dx^2 + dy^2 + dz^2)) of the change of
// the dynamic vector since the previous sample. One sample is processed at a
// time and in_ch.ready is low while it is in work. A later sample passes
// five sequencer steps per axis around one shared multiplier (gravity
// update product, then the squared change), then one cycle per root bit in
// the bit-serial square root (SAMPLE_WIDTH + 2 bits), a step to see the root
// finish and one to load the output register. A result waits in an output
// register, and the next sample is taken once that register is loaded.
// Write alpha only while the unit is idle.
module accel_gravity_removal_jerk_magnitude_unit #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  agr_in_if.sink                         in_ch,
  agr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [agr_pkg::ALPHA_W-1:0]    cfg_wdata
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int GW     = SAMPLE_WIDTH + FRAC_BITS;
  localparam int ROOT_W = SAMPLE_WIDTH + 2;
  localparam int SUM_W  = 2 * ROOT_W;
  localparam int MA_W   = (ROOT_W > agr_pkg::MUL_A_MIN_W) ? ROOT_W : agr_pkg::MUL_A_MIN_W;
  localparam int MB_W   = GW + 1;

  // Sequencer codes.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MULG  = 3'd1;
  localparam logic [2:0] S_ADDG  = 3'd2;
  localparam logic [2:0] S_DIF   = 3'd3;
  localparam logic [2:0] S_MULSQ = 3'd4;
  localparam logic [2:0] S_ACC   = 3'd5;
  localparam logic [2:0] S_ROOT  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [1:0] AX_LAST = 2'd2;

  logic [2:0]                     state_r;
  logic [2:0]                     state_nxt;
  logic [1:0]                     ax_r;
  logic [agr_pkg::ALPHA_W-1:0]    alpha_r;
  logic                           primed_r;
  logic signed [GW-1:0]           g_r    [3];
  logic signed [SW:0]             prev_r [3];
  logic signed [SW-1:0]           smp_r  [3];
  logic signed [SW+1:0]           diff_r;
  logic [SUM_W-1:0]               sum_r;
  logic [SUM_W-1:0]               sum_nxt;
  logic                           out_valid_r;
  logic [agr_pkg::JM_W-1:0]       out_data_r;

  logic                           in_xfer;
  logic                           out_free;
  logic [agr_pkg::BETA_W-1:0]     beta;
  logic signed [GW-1:0]           s_big;
  logic signed [MB_W-1:0]         d_ext;
  logic signed [MA_W-1:0]         mul_a;
  logic signed [MB_W-1:0]         mul_b;
  logic signed [MA_W+MB_W-1:0]    prod;
  logic signed [GW-1:0]           g_upd;
  logic signed [SW:0]             dyn;
  logic signed [SW+1:0]           diff;
  logic                           sq_start;
  logic                           sq_done;
  logic [ROOT_W-1:0]              sq_root;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready           = (state_r == S_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.jerk_magnitude = out_data_r;

  // Gravity update operands: beta and the distance from gravity to the sample.
  always_comb begin
    beta  = agr_pkg::BETA_ONE - {1'b0, alpha_r};
    s_big = {smp_r[ax_r], {FRAC_BITS{1'b0}}};
    d_ext = {s_big[GW-1], s_big} - {g_r[ax_r][GW-1], g_r[ax_r]};
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    if (state_r == S_MULSQ) begin
      mul_a = MA_W'(diff_r);
      mul_b = MB_W'(diff_r);
    end else begin
      mul_a = $signed(MA_W'(beta));
      mul_b = d_ext;
    end
  end

  agr_mul #(
    .A_W (MA_W),
    .B_W (MB_W)
  ) u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  // Gravity moves by floor(beta * d / 2^16); dynamic value and its change.
  always_comb begin
    g_upd   = g_r[ax_r] + GW'(prod >>> agr_pkg::ALPHA_W);
    dyn     = (SW+1)'(smp_r[ax_r]) - (SW+1)'($signed(g_r[ax_r][GW-1:FRAC_BITS]));
    diff    = (SW+2)'(dyn) - (SW+2)'(prev_r[ax_r]);
    sum_nxt = sum_r + prod[SUM_W-1:0];
  end

  assign sq_start = (state_r == S_ACC) && (ax_r == AX_LAST);

  agr_isqrt #(
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (sum_nxt),
    .done_r   (sq_done),
    .root_r   (sq_root)
  );

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_xfer && primed_r) state_nxt = S_MULG;
      S_MULG:  state_nxt = S_ADDG;
      S_ADDG:  state_nxt = S_DIF;
      S_DIF:   state_nxt = S_MULSQ;
      S_MULSQ: state_nxt = S_ACC;
      S_ACC:   state_nxt = (ax_r == AX_LAST) ? S_ROOT : S_MULG;
      S_ROOT:  if (sq_done) state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      alpha_r     <= agr_pkg::ALPHA_RESET;
      primed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        g_r[i]    <= '0;
        prev_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        alpha_r <= cfg_wdata;
      end
      // A new result is offered when none is pending or as the old one leaves; else a taken one clears.
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          ax_r <= '0;
          if (in_xfer && !primed_r) begin
            primed_r <= 1'b1;
            g_r[0]   <= {in_ch.accel_x, {FRAC_BITS{1'b0}}};
            g_r[1]   <= {in_ch.accel_y, {FRAC_BITS{1'b0}}};
            g_r[2]   <= {in_ch.accel_z, {FRAC_BITS{1'b0}}};
          end
        end
        S_ADDG: g_r[ax_r] <= g_upd;
        S_DIF:  prev_r[ax_r] <= dyn;
        S_ACC:  if (ax_r != AX_LAST) ax_r <= ax_r + 2'd1;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      smp_r[0] <= in_ch.accel_x;
      smp_r[1] <= in_ch.accel_y;
      smp_r[2] <= in_ch.accel_z;
      sum_r    <= '0;
    end
    if (state_r == S_DIF) begin
      diff_r <= diff;
    end
    if (state_r == S_ACC) begin
      sum_r <= sum_nxt;
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= agr_pkg::JM_W'(sq_root);
    end
  end

endmodule

[rtl/agr_mul.sv]
// Shared signed multiplier with a registered product.
module agr_mul #(
  parameter int A_W = 18,
  parameter int B_W = 33
) (
  input  logic                     clk,
  input  logic signed [A_W-1:0]    op_a,
  input  logic signed [B_W-1:0]    op_b,
  output logic signed [A_W+B_W-1:0] prod_r
);

  // One product per cycle; the product is registered and appears in the cycle after its operands.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

[rtl/agr_isqrt.sv]
// Bit-serial floor square root: one root bit per cycle, restoring form.
module agr_isqrt #(
  parameter int ROOT_W = 18
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2*ROOT_W-1:0]   radicand,
  output logic                  done_r,
  output logic [ROOT_W-1:0]     root_r
);

  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic                  busy_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [2*ROOT_W-1:0]   rad_r;
  logic [ROOT_W+1:0]     rem_r;
  logic [ROOT_W+1:0]     rem_sh;
  logic [ROOT_W+1:0]     trial;
  logic                  ge;

  // Bring down the next two radicand bits and try the next root bit.
  always_comb begin
    rem_sh = {rem_r[ROOT_W-1:0], rad_r[2*ROOT_W-1 -: 2]};
    trial  = {root_r, 2'b01};
    ge     = (rem_sh >= trial);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath; the root holds its value once the iteration ends.
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= rad_r << 2;
      rem_r  <= ge ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], ge};
    end
  end

endmodule

[rtl/agr_checker.sv]
// Port-level checks for the gravity removal and jerk magnitude unit.
module agr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [agr_pkg::JM_W-1:0]   jerk_magnitude
);

  // A waiting result stays offered until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before its transfer");

  // A stalled result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(jerk_magnitude))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // The computation never completes in the cycle after an input transfer.
  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !$rose(out_valid))
    else $error("result appeared right after an input transfer");

endmodule

bind accel_gravity_removal_jerk_magnitude_unit agr_checker u_agr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .jerk_magnitude (out_ch.jerk_magnitude)
);

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int SAMPLE_W    = 16;
  localparam int FRAC_W      = 16;
  // Transfer-to-result latency of one non-priming sample.
  localparam int LATENCY     = 15 + SAMPLE_W + 4;
  localparam int LONG_HOLD   = 300;
  localparam int CYCLE_LIMIT = 800000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [agr_pkg::JM_W-1:0] jerk_t;
  typedef enum int {MIX_FULL, MIX_EXTREME, MIX_MOTION} sample_mix_t;

  localparam sample_t EXTREMES [4] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [agr_pkg::ALPHA_W-1:0]   cfg_wdata;

  agr_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch ();
  agr_out_if                           out_ch ();

  accel_gravity_removal_jerk_magnitude_unit #(
    .SAMPLE_WIDTH(SAMPLE_W),
    .FRAC_BITS   (FRAC_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Gravity filter state as the block should hold it.
  logic [agr_pkg::ALPHA_W-1:0] alpha_model;
  longint                      gravity_model [3];
  longint                      prev_dyn_model [3];
  bit                          primed_model;

  jerk_t   jerk_expected [$];
  int      error_count = 0;
  longint  cycle_count = 0;
  bit      idle_en = 1'b1;
  bit      hold_long = 1'b0;
  int      motion_base [3];

  always #2 clk = ~clk;

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    error_count++;
  endtask

  // Floor square root, one result bit per pass.
  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned root = 0;
    longint unsigned rem = n;
    longint unsigned step_bit = 64'd1 << 62;
    while (step_bit > rem) step_bit >>= 2;
    while (step_bit != 0) begin
      if (rem >= root + step_bit) begin
        rem -= root + step_bit;
        root = (root >> 1) + step_bit;
      end else begin
        root >>= 1;
      end
      step_bit >>= 2;
    end
    return root;
  endfunction

  // Advance the gravity filter by one sample and queue the jerk it yields.
  function automatic void predict_jerk(sample_t sx, sample_t sy, sample_t sz);
    longint          smp [3];
    longint          beta;
    longint          dyn;
    longint          diff;
    longint unsigned sum_sq;
    smp[0] = sx;
    smp[1] = sy;
    smp[2] = sz;
    beta = 65536 - longint'(alpha_model);
    // The first sample after reset only seeds the gravity estimates.
    if (!primed_model) begin
      for (int i = 0; i < 3; i++) gravity_model[i] = smp[i] * 65536;
      primed_model = 1'b1;
      return;
    end
    sum_sq = 0;
    for (int i = 0; i < 3; i++) begin
      gravity_model[i] += (beta * (smp[i] * 65536 - gravity_model[i])) >>> 16;
      dyn = smp[i] - (gravity_model[i] >>> FRAC_W);
      diff = dyn - prev_dyn_model[i];
      sum_sq += diff * diff;
      prev_dyn_model[i] = dyn;
    end
    jerk_expected.push_back(jerk_t'(floor_sqrt(sum_sq)));
  endfunction

  // Offer one sample, with an occasional idle burst ahead of it.
  task automatic send_sample(sample_t sx, sample_t sy, sample_t sz);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.accel_x <= sx;
    in_ch.accel_y <= sy;
    in_ch.accel_z <= sz;
    do @(posedge clk); while (!in_ch.ready);
    predict_jerk(sx, sy, sz);
  endtask

  function automatic sample_t pick_sample(sample_mix_t mix, int axis);
    int v;
    case (mix)
      MIX_FULL:    return sample_t'($urandom);
      MIX_EXTREME: return EXTREMES[$urandom_range(0, 3)];
      default: begin
        // Noise of up to +/-2000 around a fixed base per axis, clipped to the sample range.
        v = motion_base[axis] + int'($urandom_range(0, 4000)) - 2000;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return sample_t'(v);
      end
    endcase
  endfunction

  task automatic send_random();
    sample_mix_t mix;
    int          r;
    r = $urandom_range(0, 9);
    mix = (r < 6) ? MIX_MOTION : (r < 8) ? MIX_FULL : MIX_EXTREME;
    send_sample(pick_sample(mix, 0), pick_sample(mix, 1), pick_sample(mix, 2));
  endtask

  // Stop offering, let every expected result arrive, then let the unit settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (jerk_expected.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_alpha(logic [agr_pkg::ALPHA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    alpha_model = value;
  endtask

  // Priming sample, then full-scale steps at the default coefficient.
  task automatic test_priming_and_extremes();
    send_sample(-32768, 32767, 0);
    send_sample(0, 0, 0);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, -32768, 32767);
    send_sample(-32768, 32767, -32768);
    send_sample(-1, -1, -1);
    send_sample(1, 0, -1);
    drain_results();
  endtask

  // Coefficient at zero (gravity tracks each sample), at full scale and at half.
  task automatic test_alpha_extremes();
    write_alpha('0);
    send_sample(12345, -23456, 32767);
    send_sample(-32768, 0, 1);
    send_sample(32767, 32767, -32768);
    drain_results();
    write_alpha('1);
    send_sample(32767, -32768, 32767);
    send_sample(-32768, 32767, -32768);
    send_sample(32767, -32768, 32767);
    send_sample(0, -1, 1);
    drain_results();
    write_alpha(16'h8000);
    send_sample(-32768, -32768, 32767);
    send_sample(32767, 32767, -32768);
    send_sample(100, -100, 16384);
    drain_results();
  endtask

  // Random samples over several coefficient settings.
  task automatic test_random_phases();
    logic [agr_pkg::ALPHA_W-1:0] phase_alpha [7];
    phase_alpha = '{agr_pkg::ALPHA_RESET, 16'h0000, 16'hFFFF, 16'h0001,
                    16'h0000, 16'h0000, 16'h0000};
    phase_alpha[4] = agr_pkg::ALPHA_W'($urandom_range(0, 65535));
    phase_alpha[5] = agr_pkg::ALPHA_W'($urandom_range(0, 65535));
    phase_alpha[6] = agr_pkg::ALPHA_W'($urandom_range(0, 65535));
    foreach (phase_alpha[p]) begin
      write_alpha(phase_alpha[p]);
      for (int i = 0; i < 3; i++) motion_base[i] = int'($urandom_range(0, 40000)) - 20000;
      repeat (170) send_random();
      drain_results();
    end
  endtask

  // Receiver holds off long enough for the unit to fill and stall its input.
  task automatic test_backpressure();
    hold_long = 1'b1;
    repeat (16) send_random();
    drain_results();
  endtask

  // Closing stretch with both sides running flat out.
  task automatic test_no_idle();
    idle_en = 1'b0;
    repeat (150) send_random();
    drain_results();
  endtask

  // Receiver ready: random hold-off bursts, plus the long hold on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_long = 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare every result transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (jerk_expected.size() == 0) begin
        report_mismatch($sformatf("unexpected jerk_magnitude %0d", out_ch.jerk_magnitude));
      end else begin
        if (out_ch.jerk_magnitude !== jerk_expected[0])
          report_mismatch($sformatf("jerk_magnitude %0d, want %0d",
                                    out_ch.jerk_magnitude, jerk_expected[0]));
        void'(jerk_expected.pop_front());
      end
    end
  end

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.accel_x <= '0;
    in_ch.accel_y <= '0;
    in_ch.accel_z <= '0;
    cfg_we        <= 1'b0;
    cfg_wdata     <= agr_pkg::ALPHA_RESET;
    rst_n         <= 1'b0;
    alpha_model   = agr_pkg::ALPHA_RESET;
    primed_model  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      gravity_model[i]  = 0;
      prev_dyn_model[i] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_priming_and_extremes();
    test_alpha_extremes();
    test_random_phases();
    test_backpressure();
    test_no_idle();

    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
